// ===== src/ara_pkg.sv =====
// ----------------------------------------------------------------------------
// ara_pkg: shared types and constants of the address range allocator
// Command and status codes, default sizes of the free region table.
// ----------------------------------------------------------------------------
package ara_pkg;

  localparam int unsigned DefMaxRegions = 128;
  localparam int unsigned DefPageBytes  = 4096;
  localparam int unsigned DefAddrBits   = 48;

  localparam int unsigned FieldAddrW = 48;
  localparam int unsigned PagesW     = 32;
  localparam int unsigned AlignW     = 16;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [PagesW-1:0] PageMax = 32'hFFFF_FFFF;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_ALIGNED = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam logic [CfgIdxW-1:0] CFG_ARENA_START = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ARENA_LIMIT = 1'b1;

endpackage

// ===== src/address_range_allocator.sv =====
// ----------------------------------------------------------------------------
// address_range_allocator: first-fit free region allocator with coalescing
// Sorted table of free regions in a memory, bump watermark up to a limit.
// ----------------------------------------------------------------------------
// channel   direction  handshake       payload
// cfg       in         valid / ready   cfg_index_i, cfg_data_i
// req       in         valid / stall   cmd_i, free_base_i, page_count_i, align_pages_i
// rsp       out        valid / stall   address_o, status_o
//
// A scan visits up to region_count table entries, and each insert or remove
// shifts the tail one entry at a time through the single-port region memory.
// Worst case about two passes plus a few merge steps.
// Reset clears count, limit, watermark, state and out_valid; the memory needs none.
// req is taken only when no response waits; a stalled rsp holds.
module address_range_allocator
  import ara_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = DefMaxRegions,
  parameter int unsigned PAGE_BYTES  = DefPageBytes,
  parameter int unsigned ADDR_BITS   = DefAddrBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ara_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ara_pkg::FieldAddrW-1:0]  cfg_data_i,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ara_pkg::CmdW-1:0]        cmd_i,
  input  logic [ara_pkg::FieldAddrW-1:0]  free_base_i,
  input  logic [ara_pkg::PagesW-1:0]      page_count_i,
  input  logic [ara_pkg::AlignW-1:0]      align_pages_i,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ara_pkg::FieldAddrW-1:0]  address_o,
  output logic [ara_pkg::StatusW-1:0]     status_o
);
  localparam int unsigned IdxW  = $clog2(MAX_REGIONS);
  localparam int unsigned CntW  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned PgSh  = $clog2(PAGE_BYTES);
  localparam int unsigned AW    = 64;
  localparam logic [AW-1:0] AddrMask = {AW{1'b1}} >> (AW - ADDR_BITS);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_REGIONS);
  localparam logic [CntW-1:0] NearCnt = CntW'(MAX_REGIONS - 2);

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DEC    = 5'd1;
  localparam logic [4:0] S_SRD    = 5'd2;
  localparam logic [4:0] S_SWT    = 5'd3;
  localparam logic [4:0] S_SCHK   = 5'd4;
  localparam logic [4:0] S_SCHK2  = 5'd5;
  localparam logic [4:0] S_WMK    = 5'd6;
  localparam logic [4:0] S_WMK2   = 5'd7;
  localparam logic [4:0] S_DRD    = 5'd8;   // drop: shift down
  localparam logic [4:0] S_DWT    = 5'd9;
  localparam logic [4:0] S_DWR    = 5'd10;
  localparam logic [4:0] S_FRD    = 5'd11;  // find first at or above
  localparam logic [4:0] S_FWT    = 5'd12;
  localparam logic [4:0] S_FCHK   = 5'd13;
  localparam logic [4:0] S_PRD    = 5'd14;  // put: shift up
  localparam logic [4:0] S_PWT    = 5'd15;
  localparam logic [4:0] S_PWR    = 5'd16;
  localparam logic [4:0] S_PFIN   = 5'd17;
  localparam logic [4:0] S_MRA    = 5'd18;  // merge: read lo
  localparam logic [4:0] S_MWA    = 5'd19;
  localparam logic [4:0] S_MRB    = 5'd20;  // read hi
  localparam logic [4:0] S_MWB    = 5'd21;
  localparam logic [4:0] S_MCHK   = 5'd22;
  localparam logic [4:0] S_MWR    = 5'd23;
  localparam logic [4:0] S_DONE   = 5'd24;
  localparam logic [4:0] S_WRONE  = 5'd25;

  // what to do after a subroutine (put / drop / merge / find)
  localparam logic [3:0] R_DONE     = 4'd0;
  localparam logic [3:0] R_FREE_FND = 4'd1;  // after find in free
  localparam logic [3:0] R_MERGE_I  = 4'd2;  // merge at ins after put
  localparam logic [3:0] R_MERGE_LO = 4'd3;  // second half of merge_near
  localparam logic [3:0] R_FREE_PRE = 4'd4;  // after pre-merge in free
  localparam logic [3:0] R_TAIL_FND = 4'd5;  // after find for aligned tail
  localparam logic [3:0] R_GAP_FND  = 4'd6;  // after find for watermark gap

  logic [4:0] state_q, state_d;
  logic [3:0] ret_q, ret_d, mret_q, mret_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] limit_q, wmark_q, wmark_d;
  logic [CmdW-1:0] cmd_q;
  logic [AW-1:0] fbase_q;
  logic [PagesW-1:0] pages_q;
  logic [AlignW-1:0] align_q;

  logic [CntW-1:0] i_q, i_d, j_q, j_d, ins_q, ins_d, mi_q, mi_d;
  logic [AW-1:0] a_q, a_d, b_q, b_d, key_q, key_d;     // scratch addresses
  logic [PagesW-1:0] p_q, p_d, pb_q, pb_d;
  logic [AW-1:0] nb_q, nb_d;                           // new entry
  logic [PagesW-1:0] np_q, np_d;
  logic [AW-1:0] res_q, res_d;
  logic [StatusW-1:0] st_q, st_d;
  logic ovalid_q, ovalid_d;

  // region memory: one port, registered read
  logic [AW-1:0]     mb_mem [MAX_REGIONS];
  logic [PagesW-1:0] mp_mem [MAX_REGIONS];
  logic [IdxW-1:0] m_addr;
  logic m_we;
  logic [AW-1:0] m_wb;
  logic [PagesW-1:0] m_wp;
  logic [AW-1:0] rb_q;
  logic [PagesW-1:0] rp_q;

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      mb_mem[m_addr] <= m_wb;
      mp_mem[m_addr] <= m_wp;
    end
    rb_q <= mb_mem[m_addr];
    rp_q <= mp_mem[m_addr];
  end

  // alignment unit in bytes and its mask, from the latched request
  logic [AW-1:0] ab_bytes;
  logic [AW-1:0] al_mask;
  assign ab_bytes = {{(AW-AlignW){1'b0}}, align_q} << PgSh;
  assign al_mask  = ab_bytes - AW'(1);

  logic [AW-1:0] bytes_w;
  assign bytes_w = {{(AW-PagesW){1'b0}}, pages_q} << PgSh;

  logic in_acc;
  assign in_stall  = (state_q != S_IDLE) || ovalid_q;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_q == S_IDLE);
  assign out_valid = ovalid_q;
  assign address_o = res_q[FieldAddrW-1:0];
  assign status_o  = st_q;

  logic [AW:0] sum_w;
  logic [PagesW:0] psum_w;
  logic [AW-1:0] rend_w;

  always_comb begin
    state_d = state_q; ret_d = ret_q; mret_d = mret_q;
    cnt_d = cnt_q; wmark_d = wmark_q;
    i_d = i_q; j_d = j_q; ins_d = ins_q; mi_d = mi_q;
    a_d = a_q; b_d = b_q; key_d = key_q; p_d = p_q; pb_d = pb_q;
    nb_d = nb_q; np_d = np_q; res_d = res_q; st_d = st_q;
    ovalid_d = ovalid_q && out_stall;
    m_addr = i_q[IdxW-1:0]; m_we = 1'b0; m_wb = nb_q; m_wp = np_q;
    sum_w = '0; psum_w = '0; rend_w = '0;
    if (cfg_valid && cfg_ready && cfg_index_i == CFG_ARENA_START) begin
      wmark_d = {{(AW-FieldAddrW){1'b0}}, cfg_data_i};
    end
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_DEC;
      S_DEC: begin
        res_d = '0; st_d = ST_IGNORED; i_d = '0; state_d = S_DONE; ret_d = R_DONE;
        case (cmd_q)
          CMD_ALLOC: if (pages_q != '0) begin st_d = ST_OK; state_d = S_SRD; end
          CMD_ALIGNED:
            if (pages_q != '0 && align_q != '0 && (align_q & (align_q - 1'b1)) == '0)
            begin
              st_d = ST_OK; state_d = S_SRD;
            end
          CMD_FREE:
            if (fbase_q != '0 && pages_q != '0) begin
              st_d = ST_OK;
              if (cnt_q >= NearCnt && cnt_q != '0) begin
                mi_d = cnt_q - 1'b1; mret_d = R_FREE_PRE; state_d = S_MRA;
              end else state_d = S_WRONE;
            end
          default: ;
        endcase
      end
      S_WRONE: begin
        // free after optional pre-merge
        if (cnt_q >= MaxCnt) begin st_d = ST_FULL; state_d = S_DONE; end
        else begin
          key_d = fbase_q; i_d = '0; ret_d = R_FREE_FND; state_d = S_FRD;
        end
      end
      // first fit scan
      S_SRD: begin
        if (i_q >= cnt_q) state_d = S_WMK;
        else state_d = S_SWT;
      end
      S_SWT: state_d = S_SCHK;
      S_SCHK: begin
        a_d = rb_q; p_d = rp_q;
        if (cmd_q == CMD_ALLOC) begin
          if (rp_q >= pages_q) begin
            res_d = rb_q;
            if (rp_q == pages_q) begin j_d = i_q; ret_d = R_DONE; state_d = S_DRD; end
            else begin
              nb_d = rb_q + bytes_w; np_d = rp_q - pages_q;
              state_d = S_PFIN; ret_d = R_DONE;  // single overwrite
            end
          end else begin i_d = i_q + 1'b1; state_d = S_SRD; end
        end else begin
          b_d = (rb_q + al_mask) & ~al_mask;   // aligned base
          state_d = S_SCHK2;
        end
      end
      S_SCHK2: begin
        // gap pages and need
        psum_w = '0;
        key_d = (b_q - a_q) >> PgSh;           // gap
        sum_w = {1'b0, (b_q - a_q) >> PgSh} + {{(AW-PagesW+1){1'b0}}, pages_q};
        if ({{(AW-PagesW+1){1'b0}}, p_q} < sum_w) begin
          i_d = i_q + 1'b1; state_d = S_SRD;
        end else begin
          res_d = b_q;
          pb_d = PagesW'(({{(AW-PagesW+1){1'b0}}, p_q}) - sum_w);  // rem
          if (((b_q - a_q) >> PgSh) != '0) begin
            nb_d = a_q; np_d = PagesW'((b_q - a_q) >> PgSh);
            ret_d = (p_q != PagesW'(sum_w) && cnt_q < MaxCnt) ? R_TAIL_FND : R_DONE;
            state_d = S_PFIN;
          end else if (p_q == PagesW'(sum_w)) begin
            j_d = i_q; ret_d = R_DONE; state_d = S_DRD;
          end else begin
            nb_d = b_q + bytes_w; np_d = PagesW'(({{(AW-PagesW+1){1'b0}}, p_q}) - sum_w);
            ret_d = R_DONE; state_d = S_PFIN;
          end
        end
      end
      // watermark path
      S_WMK: begin
        b_d = (cmd_q == CMD_ALIGNED) ? ((wmark_q + al_mask) & ~al_mask) : wmark_q;
        state_d = S_WMK2;
      end
      S_WMK2: begin
        sum_w = {1'b0, b_q} + {1'b0, bytes_w};
        if (sum_w > {1'b0, limit_q} || sum_w > {1'b0, AddrMask}) begin
          st_d = ST_NOSPACE; res_d = '0; state_d = S_DONE;
        end else begin
          res_d = b_q; wmark_d = sum_w[AW-1:0]; state_d = S_DONE;
          if (b_q != wmark_q && cnt_q < MaxCnt) begin
            nb_d = wmark_q; np_d = PagesW'((b_q - wmark_q) >> PgSh);
            key_d = wmark_q; i_d = '0; ret_d = R_GAP_FND; state_d = S_FRD;
          end
        end
      end
      // drop entry j: move j+1.. down
      S_DRD: begin
        if (j_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1; state_d = S_PFIN; i_d = j_q;
          m_addr = j_q[IdxW-1:0];
          state_d = (ret_q == R_MERGE_LO) ? S_MRA : (ret_q == R_FREE_PRE ? S_WRONE : S_DONE);
        end else begin
          m_addr = IdxW'(j_q + 1'b1); state_d = S_DWT;
        end
      end
      S_DWT: begin m_addr = IdxW'(j_q + 1'b1); state_d = S_DWR; end
      S_DWR: begin
        m_addr = j_q[IdxW-1:0]; m_we = 1'b1; m_wb = rb_q; m_wp = rp_q;
        j_d = j_q + 1'b1; state_d = S_DRD;
      end
      // find first index with base >= key
      S_FRD: begin
        m_addr = i_q[IdxW-1:0];
        if (i_q >= cnt_q) state_d = S_FCHK; else state_d = S_FWT;
      end
      S_FWT: begin m_addr = i_q[IdxW-1:0]; state_d = S_FCHK; end
      S_FCHK: begin
        if (i_q < cnt_q && rb_q < key_q) begin i_d = i_q + 1'b1; state_d = S_FRD; end
        else begin
          ins_d = i_q; j_d = cnt_q;
          case (ret_q)
            R_FREE_FND: begin
              nb_d = fbase_q; np_d = pages_q;
            end
            R_TAIL_FND: begin
              nb_d = key_q; np_d = pb_q;
            end
            default: ;
          endcase
          state_d = S_PRD;
        end
      end
      // put at ins: shift up from count
      S_PRD: begin
        if (j_q == ins_q) begin
          m_addr = ins_q[IdxW-1:0]; m_we = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (ret_q == R_TAIL_FND) state_d = S_DONE;
          else begin mi_d = ins_q; mret_d = R_DONE; state_d = S_MRA; end
        end else begin
          m_addr = IdxW'(j_q - 1'b1); state_d = S_PWT;
        end
      end
      S_PWT: begin m_addr = IdxW'(j_q - 1'b1); state_d = S_PWR; end
      S_PWR: begin
        m_addr = j_q[IdxW-1:0]; m_we = 1'b1; m_wb = rb_q; m_wp = rp_q;
        j_d = j_q - 1'b1; state_d = S_PRD;
      end
      // overwrite entry i in place
      S_PFIN: begin
        m_addr = i_q[IdxW-1:0]; m_we = 1'b1;
        if (ret_q == R_TAIL_FND) begin
          key_d = res_q + bytes_w; i_d = '0; state_d = S_FRD;
        end else state_d = S_DONE;
      end
      // merge_near(mi): first mi with mi+1, then mi-1 with mi
      S_MRA: begin
        m_addr = mi_q[IdxW-1:0];
        if (mi_q >= cnt_q) state_d = (mret_q == R_FREE_PRE) ? S_WRONE : S_DONE;
        else state_d = S_MWA;
        ret_d = R_MERGE_I;
      end
      S_MWA: begin m_addr = mi_q[IdxW-1:0]; state_d = S_MRB; end
      S_MRB: begin
        a_d = rb_q; p_d = rp_q;
        if (ret_q == R_MERGE_I) begin
          if (mi_q + 1'b1 < cnt_q) begin m_addr = IdxW'(mi_q + 1'b1); state_d = S_MWB; end
          else begin pb_d = '0; state_d = S_MWR; b_d = '0; end
        end else state_d = S_MWB;
      end
      S_MWB: begin
        m_addr = (ret_q == R_MERGE_I) ? IdxW'(mi_q + 1'b1) : IdxW'(mi_q - 1'b1);
        state_d = S_MCHK;
      end
      S_MCHK: begin
        if (ret_q == R_MERGE_I) begin b_d = rb_q; pb_d = rp_q; end
        else begin b_d = a_q; pb_d = p_q; a_d = rb_q; p_d = rp_q; end
        state_d = S_MWR;
      end
      S_MWR: begin
        // lo = a/p, hi = b/pb
        rend_w = a_q + ({{(AW-PagesW){1'b0}}, p_q} << PgSh);
        psum_w = {1'b0, p_q} + {1'b0, pb_q};
        if (ret_q == R_MERGE_I) begin
          if (mi_q + 1'b1 < cnt_q && rend_w == b_q && !psum_w[PagesW]) begin
            m_addr = mi_q[IdxW-1:0]; m_we = 1'b1; m_wb = a_q; m_wp = psum_w[PagesW-1:0];
            j_d = mi_q + 1'b1; ret_d = R_MERGE_LO; state_d = S_DRD;
          end else begin
            ret_d = R_MERGE_LO; state_d = S_MRA;
          end
          if (mi_q == '0) begin
            state_d = (mi_q + 1'b1 < cnt_q && rend_w == b_q && !psum_w[PagesW]) ?
                      S_DRD : ((mret_q == R_FREE_PRE) ? S_WRONE : S_DONE);
            ret_d = (state_d == S_DRD) ? mret_q : R_DONE;
          end
        end else begin
          if (rend_w == b_q && !psum_w[PagesW]) begin
            m_addr = IdxW'(mi_q - 1'b1); m_we = 1'b1; m_wb = a_q;
            m_wp = psum_w[PagesW-1:0];
            j_d = mi_q; ret_d = mret_q; state_d = S_DRD;
          end else state_d = (mret_q == R_FREE_PRE) ? S_WRONE : S_DONE;
        end
      end
      S_DONE: begin
        if (cmd_q == CMD_FREE || st_q != ST_OK) res_d = (st_q == ST_OK) ? '0 : '0;
        if (cmd_q == CMD_FREE) res_d = '0;
        ovalid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // second half of merge re-enters MRA with lo stage
    if (state_q == S_MRA && ret_q == R_MERGE_LO) begin
      ret_d = R_MERGE_LO;
      if (mi_q == '0 || mi_q >= cnt_q) begin
        state_d = (mret_q == R_FREE_PRE) ? S_WRONE : S_DONE;
      end
    end
    if (state_q == S_DRD && j_q + 1'b1 >= cnt_q && ret_q == R_DONE && mret_q == R_FREE_PRE
        && state_d == S_DONE && cmd_q == CMD_FREE) state_d = S_WRONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= R_DONE; mret_q <= R_DONE;
      cnt_q <= '0; limit_q <= '0; wmark_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; mret_q <= mret_d;
      cnt_q <= cnt_d; wmark_q <= wmark_d; ovalid_q <= ovalid_d;
      if (cfg_valid && cfg_ready && cfg_index_i == CFG_ARENA_LIMIT) begin
        limit_q <= {{(AW-FieldAddrW){1'b0}}, cfg_data_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_i; fbase_q <= {{(AW-FieldAddrW){1'b0}}, free_base_i};
      pages_q <= page_count_i; align_q <= align_pages_i;
    end
    i_q <= i_d; j_q <= j_d; ins_q <= ins_d; mi_q <= mi_d;
    a_q <= a_d; b_q <= b_d; key_q <= key_d; p_q <= p_d; pb_q <= pb_d;
    nb_q <= nb_d; np_q <= np_d; res_q <= res_d; st_q <= st_d;
  end

endmodule

// ===== test/address_range_allocator_test.sv =====
// ----------------------------------------------------------------------------
// address_range_allocator_test: self-checking bench of the range allocator
// A short directed table, then random allocate, aligned allocate and free
// traffic under several arena settings. Each response is checked against the
// typed row's value or a behavioral model of the free table and watermark.
// ----------------------------------------------------------------------------
module address_range_allocator_test;
  import ara_pkg::*;

  localparam int unsigned NumRegions = 128;
  localparam longint unsigned PageSize = 4096;
  localparam logic [63:0] AddrMask = 64'h0000_FFFF_FFFF_FFFF;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned CfgRow = 10;

  typedef struct {
    cmd_e        cmd;
    logic [47:0] base;
    logic [31:0] pages;
    logic [15:0] align;
    bit          typed;
    logic [47:0] ex_addr;
    status_e     ex_st;
  } row_t;

  typedef struct {
    logic [47:0] addr;
    status_e     st;
  } result_t;

  typedef struct {
    logic [47:0] addr;
    logic [31:0] pages;
  } block_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [FieldAddrW-1:0] cfg_data_i = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CmdW-1:0] cmd_i = '0;
  logic [FieldAddrW-1:0] free_base_i = '0;
  logic [PagesW-1:0] page_count_i = '0;
  logic [AlignW-1:0] align_pages_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FieldAddrW-1:0] address_o;
  logic [StatusW-1:0] status_o;

  address_range_allocator u_dut (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .in_valid, .in_stall, .cmd_i, .free_base_i, .page_count_i, .align_pages_i,
    .out_valid, .out_stall, .address_o, .status_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // model of the free region table
  logic [63:0] free_base_tab[NumRegions];
  logic [31:0] free_pages_tab[NumRegions];
  int unsigned free_cnt;
  logic [63:0] bump_ptr, arena_lo, arena_hi;

  result_t pending_results[$];
  block_t  live_blocks[$];
  int unsigned errors, activity, n_sent, n_checked, n_full, n_nospace;
  bit no_idle, hold_req;

  function automatic int unsigned slot_at_or_above(logic [63:0] addr);
    int unsigned i;
    i = 0;
    while (i < free_cnt && free_base_tab[i] < addr) i++;
    return i;
  endfunction

  function automatic void insert_region(int unsigned idx, logic [63:0] b, logic [31:0] p);
    if (free_cnt >= NumRegions || idx > free_cnt) return;
    for (int unsigned i = free_cnt; i > idx; i--) begin
      free_base_tab[i] = free_base_tab[i-1];
      free_pages_tab[i] = free_pages_tab[i-1];
    end
    free_base_tab[idx] = b;
    free_pages_tab[idx] = p;
    free_cnt++;
  endfunction

  function automatic void remove_region(int unsigned idx);
    if (idx >= free_cnt) return;
    for (int unsigned i = idx; i + 1 < free_cnt; i++) begin
      free_base_tab[i] = free_base_tab[i+1];
      free_pages_tab[i] = free_pages_tab[i+1];
    end
    free_cnt--;
  endfunction

  function automatic bit adjacent_ok(int unsigned lo);
    logic [63:0] tail, sum;
    tail = free_base_tab[lo] + 64'(free_pages_tab[lo]) * PageSize;
    sum = 64'(free_pages_tab[lo]) + 64'(free_pages_tab[lo+1]);
    return tail == free_base_tab[lo+1] && sum <= 64'(PageMax);
  endfunction

  function automatic void coalesce_at(int unsigned idx);
    if (idx >= free_cnt) return;
    if (idx + 1 < free_cnt && adjacent_ok(idx)) begin
      free_pages_tab[idx] += free_pages_tab[idx+1];
      remove_region(idx + 1);
    end
    if (idx > 0 && adjacent_ok(idx - 1)) begin
      free_pages_tab[idx-1] += free_pages_tab[idx];
      remove_region(idx);
    end
  endfunction

  function automatic status_e plain_alloc(logic [63:0] pages, output logic [63:0] addr);
    logic [63:0] tail;
    addr = '0;
    for (int unsigned i = 0; i < free_cnt; i++) begin
      if (64'(free_pages_tab[i]) >= pages) begin
        addr = free_base_tab[i];
        if (64'(free_pages_tab[i]) == pages) remove_region(i);
        else begin
          free_base_tab[i] += pages * PageSize;
          free_pages_tab[i] -= 32'(pages);
        end
        return ST_OK;
      end
    end
    tail = bump_ptr + pages * PageSize;
    if (tail > arena_hi || tail > AddrMask) return ST_NOSPACE;
    addr = bump_ptr;
    bump_ptr = tail;
    return ST_OK;
  endfunction

  function automatic status_e aligned_alloc(logic [63:0] pages, logic [63:0] align,
                                            output logic [63:0] addr);
    logic [63:0] unit, al, tail, b, gap, need, rest;
    int unsigned ins;
    unit = align * PageSize;
    addr = '0;
    for (int unsigned i = 0; i < free_cnt; i++) begin
      b = free_base_tab[i];
      al = ((b + unit - 1) / unit) * unit;
      gap = (al - b) / PageSize;
      need = gap + pages;
      if (64'(free_pages_tab[i]) < need) continue;
      rest = 64'(free_pages_tab[i]) - need;
      if (gap > 0) begin
        free_pages_tab[i] = 32'(gap);
        // tail piece goes back only if there is room
        if (rest > 0 && free_cnt < NumRegions) begin
          tail = al + pages * PageSize;
          insert_region(slot_at_or_above(tail), tail, 32'(rest));
        end
      end else if (rest == 0) remove_region(i);
      else begin
        free_base_tab[i] = al + pages * PageSize;
        free_pages_tab[i] = 32'(rest);
      end
      addr = al;
      return ST_OK;
    end
    al = ((bump_ptr + unit - 1) / unit) * unit;
    tail = al + pages * PageSize;
    if (tail > arena_hi || tail > AddrMask) return ST_NOSPACE;
    if (al > bump_ptr && free_cnt < NumRegions) begin
      ins = slot_at_or_above(bump_ptr);
      insert_region(ins, bump_ptr, 32'((al - bump_ptr) / PageSize));
      coalesce_at(ins);
    end
    bump_ptr = tail;
    addr = al;
    return ST_OK;
  endfunction

  function automatic status_e release_range(logic [63:0] b, logic [31:0] pages);
    int unsigned idx;
    // nearly full: squeeze the last entry first
    if (free_cnt >= NumRegions - 2 && free_cnt > 0) coalesce_at(free_cnt - 1);
    if (free_cnt >= NumRegions) return ST_FULL;
    idx = slot_at_or_above(b);
    insert_region(idx, b, pages);
    coalesce_at(idx);
    return ST_OK;
  endfunction

  function automatic result_t predict_response(cmd_e cmd, logic [47:0] b,
                                               logic [31:0] pages, logic [15:0] align);
    result_t r;
    logic [63:0] a;
    r.st = ST_IGNORED;
    a = '0;
    case (cmd)
      CMD_ALLOC: if (pages != 0) r.st = plain_alloc(64'(pages), a);
      CMD_ALIGNED: begin
        if (pages != 0 && align != 0 && (align & (align - 16'd1)) == 0)
          r.st = aligned_alloc(64'(pages), 64'(align), a);
      end
      CMD_FREE: if (b != 0 && pages != 0) r.st = release_range(64'(b), pages);
      default: ;
    endcase
    if (r.st != ST_OK) a = '0;
    r.addr = a[47:0];
    return r;
  endfunction

  task automatic send_request(cmd_e cmd, logic [47:0] b, logic [31:0] pages,
                              logic [15:0] align, bit typed, result_t ex);
    result_t r;
    if (!no_idle && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_i <= cmd;
    free_base_i <= b;
    page_count_i <= pages;
    align_pages_i <= align;
    do @(posedge clk_i); while (in_stall);
    activity++;
    n_sent++;
    r = predict_response(cmd, b, pages, align);
    if (r.st == ST_OK && cmd != CMD_FREE) live_blocks.push_back('{r.addr, pages});
    if (r.st == ST_FULL) n_full++;
    if (r.st == ST_NOSPACE) n_nospace++;
    pending_results.push_back(typed ? ex : r);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [47:0] data);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (16) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready);
    activity++;
    cfg_valid <= 1'b0;
    if (idx == CFG_ARENA_START) begin
      arena_lo = 64'(data);
      bump_ptr = 64'(data);
    end else arena_hi = 64'(data);
  endtask

  task automatic random_request();
    int unsigned pick, k;
    logic [31:0] pg;
    block_t blk;
    result_t none;
    none = '{'0, ST_OK};
    pick = $urandom_range(99);
    if (pick < 35) begin
      pg = ($urandom_range(19) == 0) ? 32'($urandom) : 32'($urandom_range(1, 8));
      send_request(CMD_ALLOC, 48'({$urandom, $urandom}), pg, 16'($urandom), 0, none);
    end else if (pick < 55) begin
      pg = ($urandom_range(19) == 0) ? 32'($urandom) : 32'($urandom_range(1, 6));
      send_request(CMD_ALIGNED, '0, pg, 16'(1) << $urandom_range(0, 15), 0, none);
    end else if (pick < 90) begin
      if (live_blocks.size() > 0 && $urandom_range(9) < 8) begin
        k = $urandom_range(live_blocks.size() - 1);
        blk = live_blocks[k];
        live_blocks.delete(k);
        send_request(CMD_FREE, blk.addr, blk.pages, '0, 0, none);
      end else begin
        send_request(CMD_FREE, 48'({$urandom, $urandom}) & ~48'hFFF,
                     32'($urandom_range(1, 64)), '0, 0, none);
      end
    end else begin
      send_request(cmd_e'($urandom_range(3)), 48'({$urandom, $urandom}), 32'($urandom),
                   16'($urandom), 0, none);
    end
  endtask

  // response side: check, then pick the stall for the next cycle
  initial begin
    int unsigned hold_left;
    result_t ex;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        activity++;
        if (pending_results.size() == 0) begin
          $error("unexpected transaction: address %h status %0d", address_o, status_o);
          errors++;
        end else begin
          ex = pending_results.pop_front();
          n_checked++;
          if (address_o !== ex.addr) begin
            $error("address: expected %h actual %h", ex.addr, address_o);
            errors++;
          end
          if (status_o !== ex.st) begin
            $error("status: expected %0d actual %0d", ex.st, status_o);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else out_stall <= !no_idle && $urandom_range(99) < 8;
    end
  end

  initial begin
    int unsigned quiet, seen;
    quiet = 0;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (activity != seen) begin
        seen = activity;
        quiet = 0;
      end else if (++quiet >= StallLimit) begin
        $display("timeout after %0d idle cycles", quiet);
        $display("address_range_allocator: mismatch");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    logic [47:0] arena_cfg[4][2];
    logic [47:0] fill_addr[$];
    result_t none;
    none = '{'0, ST_OK};
    free_cnt = 0;
    bump_ptr = '0;
    arena_lo = '0;
    arena_hi = '0;
    rows = '{
      '{CMD_ALLOC,   48'h0, 32'd1, 16'h0, 1, 48'h0, ST_NOSPACE},
      '{CMD_ALLOC,   48'h0, 32'd0, 16'h0, 1, 48'h0, ST_IGNORED},
      '{CMD_NONE,    48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 48'h0, ST_IGNORED},
      '{CMD_ALIGNED, 48'h0, 32'd1, 16'h0, 1, 48'h0, ST_IGNORED},
      '{CMD_ALIGNED, 48'h0, 32'd1, 16'hFFFF, 1, 48'h0, ST_IGNORED},
      '{CMD_ALIGNED, 48'h0, 32'd1, 16'd3, 1, 48'h0, ST_IGNORED},
      '{CMD_FREE,    48'h0, 32'd5, 16'h0, 1, 48'h0, ST_IGNORED},
      '{CMD_FREE,    48'h1000, 32'd0, 16'h0, 1, 48'h0, ST_IGNORED},
      '{CMD_ALIGNED, 48'h0, 32'd1, 16'h8000, 1, 48'h0, ST_NOSPACE},
      '{CMD_ALLOC,   48'h0, 32'hFFFF_FFFF, 16'h0, 1, 48'h0, ST_NOSPACE},
      // arena now starts at 0x1000 and runs to the top
      '{CMD_ALLOC,   48'h0, 32'd1, 16'h0, 1, 48'h1000, ST_OK},
      '{CMD_ALIGNED, 48'h0, 32'd2, 16'h10, 0, 48'h0, ST_OK},
      '{CMD_ALLOC,   48'h0, 32'd3, 16'h0, 0, 48'h0, ST_OK},
      '{CMD_FREE,    48'hFFFF_FFFF_F000, 32'hFFFF_FFFF, 16'h0, 1, 48'h0, ST_OK},
      '{CMD_FREE,    48'h2000, 32'd1, 16'h0, 0, 48'h0, ST_OK},
      '{CMD_ALLOC,   48'h0, 32'hFFFF_FFFF, 16'h0, 0, 48'h0, ST_OK},
      '{CMD_ALIGNED, 48'h0, 32'd1, 16'h8000, 0, 48'h0, ST_OK},
      '{CMD_ALLOC,   48'h0, 32'h10, 16'h0, 0, 48'h0, ST_OK},
      '{CMD_FREE,    48'h5555_5555_5000, 32'hAAAA_AAAA, 16'h5555, 0, 48'h0, ST_OK},
      // neighbors whose page sum overflows stay apart
      '{CMD_FREE,    48'h1000_0000_0000, 32'hFFFF_FFFF, 16'h0, 0, 48'h0, ST_OK},
      '{CMD_FREE,    48'h1FFF_FFFF_F000, 32'd1, 16'h0, 0, 48'h0, ST_OK},
      '{CMD_ALIGNED, 48'hAAAA_AAAA_AAAA, 32'hFFFF_FFFF, 16'd1, 0, 48'h0, ST_OK}
    };
    arena_cfg = '{
      '{48'h10_0000, 48'h410_0000},
      '{48'h0, 48'hFFFF_FFFF_FFFF},
      '{48'hFFFF_FFF0_0000, 48'hFFFF_FFFF_FFFF},
      '{48'h8000_0000, 48'h8000_0000}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (i == CfgRow) begin
        write_register(CFG_ARENA_START, 48'h1000);
        write_register(CFG_ARENA_LIMIT, 48'hFFFF_FFFF_FFFF);
      end
      send_request(rows[i].cmd, rows[i].base, rows[i].pages, rows[i].align,
                   rows[i].typed, '{rows[i].ex_addr, rows[i].ex_st});
    end

    for (int ph = 0; ph < 4; ph++) begin
      write_register(CFG_ARENA_START, arena_cfg[ph][0]);
      write_register(CFG_ARENA_LIMIT, arena_cfg[ph][1]);
      no_idle = (ph == 2);
      if (ph == 0) hold_req = 1;
      if (ph == 1) begin
        // scattered single pages until the table overflows
        fill_addr.delete();
        for (int k = 0; k < 260; k++) begin
          send_request(CMD_ALLOC, '0, 32'd1, '0, 0, none);
          fill_addr.push_back(live_blocks[$].addr);
          void'(live_blocks.pop_back());
        end
        for (int k = 0; k < 260; k += 2)
          send_request(CMD_FREE, fill_addr[k], 32'd1, '0, 0, none);
      end
      for (int k = 0; k < ItemsPerPhase; k++) random_request();
    end
    no_idle = 0;

    @(posedge clk_i);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (64) @(posedge clk_i);
    $display("sent %0d requests, checked %0d responses over six arena settings",
             n_sent, n_checked);
    $display("%0d exhausted, %0d dropped frees on a full table", n_nospace, n_full);
    if (errors == 0) $display("address_range_allocator: match");
    else $display("address_range_allocator: mismatch");
    $finish;
  end

endmodule
